/* src/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types and constants of the touch press classifier
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

	localparam int TS_W    = 32;
	localparam int RUN_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX_MS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN_MS    = 2'd3;

	localparam logic             RST_ACTIVE_HIGH    = 1'b0;
	localparam logic [RUN_W-1:0] RST_DEBOUNCE_COUNT = 8'd2;
	localparam logic [TS_W-1:0]  RST_SHORT_MAX_MS   = 32'd600;
	localparam logic [TS_W-1:0]  RST_LONG_MIN_MS    = 32'd1500;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_SHORT    = 3'd2,
		EV_LONG     = 3'd3,
		EV_DEADBAND = 3'd4
	} event_t;

	typedef struct packed {
		logic             active_high;
		logic [RUN_W-1:0] debounce_count;
		logic [TS_W-1:0]  short_max_ms;
		logic [TS_W-1:0]  long_min_ms;
	} cfg_t;

endpackage

`default_nettype wire

/* src/tpc_ifs.sv */
// ----------------------------------------------------------------------------
// tpc_ifs
// valid/ready channels for pin samples and classified results
// ----------------------------------------------------------------------------
`default_nettype none

interface tpc_samp_if;
	logic                    valid;
	logic                    ready;
	logic                    pin_level;
	logic [tpc_pkg::TS_W-1:0] now_ms;

	modport source (output valid, output pin_level, output now_ms, input ready);
	modport sink (input valid, input pin_level, input now_ms, output ready);
endinterface

interface tpc_res_if;
	logic                    valid;
	logic                    ready;
	logic                    stable_touch;
	logic [2:0]              event_res;
	logic [tpc_pkg::TS_W-1:0] hold_ms;

	modport source (output valid, output stable_touch, output event_res, output hold_ms,
		input ready);
	modport sink (input valid, input stable_touch, input event_res, input hold_ms,
		output ready);
endinterface

`default_nettype wire

/* src/touch_press_classifier.sv */
// ----------------------------------------------------------------------------
// touch_press_classifier
// debounced touch pin sampler with short, long and deadband release events
// ----------------------------------------------------------------------------
// Takes one pin sample per clock and returns one result per sample, so
// throughput is one item per cycle, while the result side does not stall. A
// sample is captured in an input register, run through the debounce counter,
// the timestamp subtract and the threshold compares combinationally, and
// lands in a result register, which lets a new sample enter while the previous
// result waits to be taken. Configuration registers reset to active-low
// polarity, a debounce count of 2, a 600 ms short limit and a 1500 ms long
// limit, and should only be written while no items are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_press_classifier (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data,
	tpc_samp_if.sink                            samp,
	tpc_res_if.source                           res
);

	tpc_pkg::cfg_t cfg;

	tpc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	tpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.samp   (samp),
		.res    (res)
	);

endmodule

`default_nettype wire

/* src/tpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tpc_cfg_regs
// configuration register file: polarity, debounce count, press thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [tpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tpc_pkg::cfg_t                         cfg
);

	tpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high    <= tpc_pkg::RST_ACTIVE_HIGH;
			cfg_q.debounce_count <= tpc_pkg::RST_DEBOUNCE_COUNT;
			cfg_q.short_max_ms   <= tpc_pkg::RST_SHORT_MAX_MS;
			cfg_q.long_min_ms    <= tpc_pkg::RST_LONG_MIN_MS;
		end else if (cfg_we) begin
			case (cfg_idx)
				tpc_pkg::CFG_ACTIVE_HIGH: begin
					cfg_q.active_high <= cfg_data[0];
				end
				tpc_pkg::CFG_DEBOUNCE_COUNT: begin
					cfg_q.debounce_count <= cfg_data[tpc_pkg::RUN_W-1:0];
				end
				tpc_pkg::CFG_SHORT_MAX_MS: begin
					cfg_q.short_max_ms <= cfg_data[tpc_pkg::TS_W-1:0];
				end
				tpc_pkg::CFG_LONG_MIN_MS: begin
					cfg_q.long_min_ms <= cfg_data[tpc_pkg::TS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/tpc_core.sv */
// ----------------------------------------------------------------------------
// tpc_core
// sample register, debounce state, press timing and release classification
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire tpc_pkg::cfg_t cfg,
	tpc_samp_if.sink     samp,
	tpc_res_if.source    res
);

	// input stage
	logic                     valid_s1;
	logic                     level_s1;
	logic [tpc_pkg::TS_W-1:0] now_s1;

	// debounce and timing state
	logic                      last_q;
	logic [tpc_pkg::RUN_W-1:0] run_q;
	logic                      deb_q;
	logic [tpc_pkg::TS_W-1:0]  start_q;

	// result register
	logic                     out_valid_q;
	logic                     stable_q;
	tpc_pkg::event_t          event_q;
	logic [tpc_pkg::TS_W-1:0] hold_q;

	logic                      adv;
	logic                      touched;
	logic [tpc_pkg::RUN_W-1:0] run_nx;
	logic                      fire;
	logic [tpc_pkg::TS_W-1:0]  hold_diff;
	tpc_pkg::event_t           event_nx;
	logic [tpc_pkg::TS_W-1:0]  hold_nx;

	assign adv        = valid_s1 && (!out_valid_q || res.ready);
	assign samp.ready = !valid_s1 || adv;

	always_comb begin
		touched   = cfg.active_high ? level_s1 : ~level_s1;
		run_nx    = run_q;
		if (touched != last_q) begin
			run_nx = {{(tpc_pkg::RUN_W-1){1'b0}}, 1'b1};
		end else if (run_q < cfg.debounce_count) begin
			run_nx = run_q + {{(tpc_pkg::RUN_W-1){1'b0}}, 1'b1};
		end
		fire      = (run_nx >= cfg.debounce_count) && (deb_q != touched);
		hold_diff = now_s1 - start_q;
		event_nx  = tpc_pkg::EV_NONE;
		hold_nx   = '0;
		if (fire) begin
			if (touched) begin
				event_nx = tpc_pkg::EV_PRESSED;
			end else begin
				hold_nx = hold_diff;
				if (hold_diff <= cfg.short_max_ms) begin
					event_nx = tpc_pkg::EV_SHORT;
				end else if (hold_diff >= cfg.long_min_ms) begin
					event_nx = tpc_pkg::EV_LONG;
				end else begin
					event_nx = tpc_pkg::EV_DEADBAND;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samp.ready) begin
			valid_s1 <= samp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samp.valid && samp.ready) begin
			level_s1 <= samp.pin_level;
			now_s1   <= samp.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			run_q   <= '0;
			deb_q   <= 1'b0;
			start_q <= '0;
		end else if (adv) begin
			last_q <= touched;
			run_q  <= run_nx;
			if (fire) begin
				deb_q <= touched;
				if (touched) begin
					start_q <= now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stable_q <= fire ? touched : deb_q;
			event_q  <= event_nx;
			hold_q   <= hold_nx;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.stable_touch = stable_q;
	assign res.event_res    = event_q;
	assign res.hold_ms      = hold_q;

	a_press_is_touched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q == tpc_pkg::EV_PRESSED |-> stable_q)
		else $error("press event with stable state released");

	a_release_is_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (event_q == tpc_pkg::EV_SHORT || event_q == tpc_pkg::EV_LONG ||
		event_q == tpc_pkg::EV_DEADBAND) |-> !stable_q)
		else $error("release event with stable state touched");

	a_hold_zero_otherwise: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (event_q == tpc_pkg::EV_NONE || event_q == tpc_pkg::EV_PRESSED)
		|-> hold_q == '0)
		else $error("hold time on a non-release item");

	a_fire_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		adv && fire |=> deb_q != $past(deb_q))
		else $error("stable state did not change on accepted transition");

	a_stable_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> stable_q == deb_q)
		else $error("result stable state differs from debounce state");

endmodule

`default_nettype wire
